// ===== src/xsr_pkg.sv =====
// ----------------------------------------------------------------------------
// xsr_pkg
// Shared types and constants of the xoshiro256** generator with splitmix64
// seeding.
// ----------------------------------------------------------------------------
`default_nettype none

package xsr_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;
    localparam int unsigned NUM_WORDS = 4;
    localparam int unsigned IDX_W = 2;

    localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94d049bb133111eb;

    localparam logic FUNC_RESEED = 1'b0;
    localparam logic FUNC_NEXT   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX_A,
        S_WAIT_A,
        S_WAIT_B,
        S_NEXT
    } t_state;

    typedef enum logic [1:0] {
        M_LO_LO,
        M_LO_HI,
        M_HI_LO,
        M_FINISH
    } t_mul_step;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] product;
    } t_mul_rsp;

endpackage

`default_nettype wire

// ===== src/xsr_mul.sv =====
// ----------------------------------------------------------------------------
// xsr_mul
// Iterative 64x64 multiplier, low 64 bits of the product, built around one
// 32x32 multiplier with a registered product. Four steps per operation.
// ----------------------------------------------------------------------------
`default_nettype none

module xsr_mul (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  xsr_pkg::t_mul_req        i_req,
    output xsr_pkg::t_mul_rsp        o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    xsr_pkg::t_mul_step            r_step;
    logic [xsr_pkg::WORD_W-1:0]    r_a;
    logic [xsr_pkg::WORD_W-1:0]    r_b;
    logic [xsr_pkg::WORD_W-1:0]    r_prod;
    logic [xsr_pkg::WORD_W-1:0]    r_acc;

    logic [xsr_pkg::HALF_W-1:0]    w_opa;
    logic [xsr_pkg::HALF_W-1:0]    w_opb;
    logic [xsr_pkg::WORD_W-1:0]    w_mul;
    logic [xsr_pkg::HALF_W-1:0]    w_acc_hi;

    always_comb begin
        case (r_step)
            xsr_pkg::M_LO_LO: begin
                w_opa = r_a[31:0];
                w_opb = r_b[31:0];
            end
            xsr_pkg::M_LO_HI: begin
                w_opa = r_a[31:0];
                w_opb = r_b[63:32];
            end
            default: begin
                w_opa = r_a[63:32];
                w_opb = r_b[31:0];
            end
        endcase
    end

    assign w_mul    = {32'd0, w_opa} * {32'd0, w_opb};
    assign w_acc_hi = r_acc[63:32] + r_prod[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= xsr_pkg::M_LO_LO;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_req.start) begin
                    r_busy <= 1'b1;
                    r_step <= xsr_pkg::M_LO_LO;
                end
            end else begin
                case (r_step)
                    xsr_pkg::M_LO_LO: r_step <= xsr_pkg::M_LO_HI;
                    xsr_pkg::M_LO_HI: r_step <= xsr_pkg::M_HI_LO;
                    xsr_pkg::M_HI_LO: r_step <= xsr_pkg::M_FINISH;
                    default: begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        r_step <= xsr_pkg::M_LO_LO;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy) begin
            if (i_req.start) begin
                r_a <= i_req.a;
                r_b <= i_req.b;
            end
        end else begin
            case (r_step)
                xsr_pkg::M_LO_LO: r_prod <= w_mul;
                xsr_pkg::M_LO_HI: begin
                    r_acc  <= r_prod;
                    r_prod <= w_mul;
                end
                xsr_pkg::M_HI_LO: begin
                    r_acc[63:32] <= w_acc_hi;
                    r_prod       <= w_mul;
                end
                default: r_acc[63:32] <= w_acc_hi;
            endcase
        end
    end

    assign o_rsp.busy    = r_busy;
    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

`default_nettype wire

// ===== src/xoshiro256ss_generator.sv =====
// ----------------------------------------------------------------------------
// xoshiro256ss_generator
// xoshiro256** pseudo-random generator with splitmix64 reseeding.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_axis_tuser selects the operation (0 reseed, 1 next word),
//   s_axis_tdata carries the 64-bit seed, read only on a reseed.
//   Output stream: m_axis_tdata carries one 64-bit word per next request;
//   a reseed produces no output transaction.
//   Next request: the result is registered in S_NEXT once the output register
//   is free; a new input transaction is taken only after that, back in S_IDLE.
//   Reseed: four splitmix64 rounds, each two 64x64 multiplies on a shared
//   32x32 multiplier at 4 steps each plus hand-off; s_axis_tready
//   stays low meanwhile.
//   Reset (synchronous, active low) clears the state to zero, so next
//   requests return zero until the first reseed.
//   If the receiver stalls with a result pending, a following next request
//   waits in S_NEXT until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module xoshiro256ss_generator (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // [63:0] seed_value
    input  wire  [0:0]  s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] random_word
);

    xsr_pkg::t_state               r_state;
    xsr_pkg::t_state               n_state;
    logic [xsr_pkg::WORD_W-1:0]    r_words [xsr_pkg::NUM_WORDS];
    logic [xsr_pkg::WORD_W-1:0]    r_counter;
    logic [xsr_pkg::IDX_W-1:0]     r_idx;
    logic [xsr_pkg::WORD_W-1:0]    r_mul5;
    logic                          r_out_valid;
    logic [xsr_pkg::WORD_W-1:0]    r_out_data;

    xsr_pkg::t_mul_req             w_mul_req;
    xsr_pkg::t_mul_rsp             w_mul_rsp;
    logic                          w_accept;
    logic                          w_out_free;
    logic [xsr_pkg::WORD_W-1:0]    w_prod;
    logic [xsr_pkg::WORD_W-1:0]    w_rot;
    logic [xsr_pkg::WORD_W-1:0]    w_t2;
    logic [xsr_pkg::WORD_W-1:0]    w_t3;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_prod     = w_mul_rsp.product;
    assign w_rot      = {r_mul5[56:0], r_mul5[63:57]};
    assign w_t2       = r_words[2] ^ r_words[0];
    assign w_t3       = r_words[3] ^ r_words[1];

    xsr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            xsr_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser[0] == xsr_pkg::FUNC_NEXT) begin
                        n_state = xsr_pkg::S_NEXT;
                    end else begin
                        n_state = xsr_pkg::S_MIX_A;
                    end
                end
            end
            xsr_pkg::S_MIX_A: n_state = xsr_pkg::S_WAIT_A;
            xsr_pkg::S_WAIT_A: begin
                if (w_mul_rsp.done) begin
                    n_state = xsr_pkg::S_WAIT_B;
                end
            end
            xsr_pkg::S_WAIT_B: begin
                if (w_mul_rsp.done) begin
                    n_state = (r_idx == xsr_pkg::IDX_W'(xsr_pkg::NUM_WORDS - 1))
                            ? xsr_pkg::S_IDLE : xsr_pkg::S_MIX_A;
                end
            end
            xsr_pkg::S_NEXT: begin
                if (w_out_free) begin
                    n_state = xsr_pkg::S_IDLE;
                end
            end
            default: n_state = xsr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready   = 1'b0;
        w_mul_req.start = 1'b0;
        w_mul_req.a     = r_counter ^ (r_counter >> 30);
        w_mul_req.b     = xsr_pkg::MIX_MUL_A;
        unique case (r_state)
            xsr_pkg::S_IDLE:  s_axis_tready = 1'b1;
            xsr_pkg::S_MIX_A: w_mul_req.start = 1'b1;
            xsr_pkg::S_WAIT_A: begin
                w_mul_req.start = w_mul_rsp.done;
                w_mul_req.a     = w_prod ^ (w_prod >> 27);
                w_mul_req.b     = xsr_pkg::MIX_MUL_B;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xsr_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < xsr_pkg::NUM_WORDS; i++) begin
                r_words[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == xsr_pkg::S_NEXT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == xsr_pkg::S_IDLE && w_accept
                    && s_axis_tuser[0] == xsr_pkg::FUNC_NEXT) begin
                r_words[0] <= r_words[0] ^ w_t3;
                r_words[1] <= r_words[1] ^ w_t2;
                r_words[2] <= w_t2 ^ (r_words[1] << 17);
                r_words[3] <= {w_t3[18:0], w_t3[63:19]};
            end
            if (r_state == xsr_pkg::S_WAIT_B && w_mul_rsp.done) begin
                r_words[r_idx] <= w_prod ^ (w_prod >> 31);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == xsr_pkg::S_IDLE && w_accept) begin
            r_counter <= s_axis_tdata + xsr_pkg::GOLDEN_STEP;
            r_idx     <= '0;
            r_mul5    <= r_words[1] + (r_words[1] << 2);
        end
        if (r_state == xsr_pkg::S_WAIT_B && w_mul_rsp.done) begin
            r_counter <= r_counter + xsr_pkg::GOLDEN_STEP;
            r_idx     <= r_idx + 1'b1;
        end
        if (r_state == xsr_pkg::S_NEXT && w_out_free) begin
            r_out_data <= w_rot + (w_rot << 3);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTH
    a_ready_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_mul_rsp.busy)
        else $error("input ready while multiplier busy");

    a_seed_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser[0] == xsr_pkg::FUNC_RESEED) |=> !$rose(m_axis_tvalid))
        else $error("reseed produced an output transaction");

    a_next_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_rsp.done |-> (r_state == xsr_pkg::S_WAIT_A || r_state == xsr_pkg::S_WAIT_B))
        else $error("multiplier done outside a wait state");
`endif

endmodule

`default_nettype wire
